@@ hdl/nwc_pkg.sv @@
// Shared types, widths and window helpers for the normalized WOLA combiner.
// Used by nwc_divider and normalized_wola_combine_core; depends on nothing.

package nwc_pkg;

  localparam int SAMPLE_BITS       = 32;
  localparam int INDEX_W           = 8;
  localparam int WINDOW_HALF_WIDTH = 105;
  localparam int WEIGHT_FULL       = 50;
  localparam logic [INDEX_W-1:0] FRAME_LENGTH_RESET = INDEX_W'(160);

  // Integer weight is 0..WEIGHT_FULL, denominator is ip^2 + ic^2.
  localparam int WEIGHT_W = $clog2(WEIGHT_FULL + 1);
  localparam int DEN_W    = $clog2(2 * WEIGHT_FULL * WEIGHT_FULL + 1);
  localparam int FULL_W   = $clog2(WEIGHT_FULL + 1);

  // Weighted sum and its scaled magnitude.
  localparam int PROD_W = SAMPLE_BITS + WEIGHT_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = SUM_W + FULL_W;
  localparam int TOT_W  = MAG_W + 2;

  // Accept edge to result strobe: five front stages, one per quotient bit, two back.
  localparam int LATENCY = MAG_W + 7;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] acc;
    logic                          neg;
    logic                          no_weight;
  } div_side_t;

  // Trapezoid weight from the distance to the window center.
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [INDEX_W-1:0] span);
    logic [INDEX_W-1:0] edge_dist;
    logic [WEIGHT_W-1:0] w;
    edge_dist = INDEX_W'(WINDOW_HALF_WIDTH) - span;
    if (span > INDEX_W'(WINDOW_HALF_WIDTH)) begin
      w = '0;
    end else if (edge_dist < INDEX_W'(WEIGHT_FULL)) begin
      w = edge_dist[WEIGHT_W-1:0];
    end else begin
      w = WEIGHT_W'(WEIGHT_FULL);
    end
    return w;
  endfunction

endpackage

@@ hdl/normalized_wola_combine_core.sv @@
// Top level of the normalized weighted overlap-add combiner.
// Depends on nwc_pkg and nwc_divider.

// One request per clock: start is taken whenever it is high (busy stays low),
// and each result passes five front stages for weights, products and scaling,
// one stage per quotient bit of the 46-bit restoring divider, then sign and
// saturating add, and is strobed by done for one cycle. The receiver cannot
// hold results off, so capture them on done.
// Write frame_length through cfg_we/cfg_wdata only while no request is in flight.

module normalized_wola_combine_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [nwc_pkg::INDEX_W-1:0]            sample_index,
  input  logic signed [nwc_pkg::SAMPLE_BITS-1:0] older_sample,
  input  logic signed [nwc_pkg::SAMPLE_BITS-1:0] newer_sample,
  input  logic signed [nwc_pkg::SAMPLE_BITS-1:0] acc_in,
  input  logic                                   cfg_we,
  input  logic [nwc_pkg::INDEX_W-1:0]            cfg_wdata,
  output logic                                   done,
  output logic signed [nwc_pkg::SAMPLE_BITS-1:0] acc_out,
  output logic                                   no_weight,
  output logic                                   saturated
);

  localparam int SB = nwc_pkg::SAMPLE_BITS;
  localparam int IW = nwc_pkg::INDEX_W;
  localparam int WW = nwc_pkg::WEIGHT_W;

  logic [IW-1:0] frame_length;

  // Stage 1: captured request
  logic                 v1;
  logic [IW-1:0]        n1;
  logic signed [SB-1:0] prev1, curr1, acc1;
  // Stage 2: weights
  logic                 v2;
  logic [WW-1:0]        ip2, ic2;
  logic signed [SB-1:0] prev2, curr2, acc2;
  // Stage 3: products and denominator
  logic                                  v3;
  logic signed [nwc_pkg::PROD_W-1:0]     pp3, pc3;
  logic [nwc_pkg::DEN_W-1:0]             den3;
  logic signed [SB-1:0]                  acc3;
  logic                                  nw3;
  // Stage 4: weighted sum
  logic                                  v4;
  logic signed [nwc_pkg::SUM_W-1:0]      sum4;
  logic [nwc_pkg::DEN_W-1:0]             den4;
  logic signed [SB-1:0]                  acc4;
  logic                                  nw4;
  // Stage 5: divider inputs
  logic                                  v5;
  logic [nwc_pkg::MAG_W-1:0]             mag5;
  logic [nwc_pkg::DEN_W-1:0]             den5;
  nwc_pkg::div_side_t                    side5;
  // Divider outputs
  logic                                  dv;
  logic [nwc_pkg::MAG_W-1:0]             dquot;
  nwc_pkg::div_side_t                    dside;
  // Signed quotient stage
  logic                                  vq;
  logic signed [nwc_pkg::MAG_W:0]        qs;
  logic signed [SB-1:0]                  accq;
  logic                                  nwq;

  logic [IW:0]                           dist_c;
  logic [IW:0]                           abs_c;
  logic [nwc_pkg::SUM_W-1:0]             sum_abs;
  logic signed [nwc_pkg::TOT_W-1:0]      total;
  logic signed [nwc_pkg::TOT_W-1:0]      sat_hi, sat_lo;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= nwc_pkg::FRAME_LENGTH_RESET;
    end else if (cfg_we) begin
      frame_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      vq   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      vq   <= dv;
      done <= vq;
    end
  end

  // Distance of n from the current frame window center, as a magnitude.
  always_comb begin
    dist_c = {1'b0, n1} - {1'b0, frame_length};
    abs_c  = dist_c[IW] ? -dist_c : dist_c;
  end

  always_comb begin
    sum_abs = sum4[nwc_pkg::SUM_W-1] ? nwc_pkg::SUM_W'(-sum4) : nwc_pkg::SUM_W'(sum4);
  end

  always_ff @(posedge clk) begin
    n1    <= sample_index;
    prev1 <= older_sample;
    curr1 <= newer_sample;
    acc1  <= acc_in;

    ip2   <= nwc_pkg::weight_of(n1);
    ic2   <= nwc_pkg::weight_of(abs_c[IW-1:0]);
    prev2 <= prev1;
    curr2 <= curr1;
    acc2  <= acc1;

    pp3  <= $signed({{(nwc_pkg::PROD_W-SB){prev2[SB-1]}}, prev2})
          * $signed({{(nwc_pkg::PROD_W-WW){1'b0}}, ip2});
    pc3  <= $signed({{(nwc_pkg::PROD_W-SB){curr2[SB-1]}}, curr2})
          * $signed({{(nwc_pkg::PROD_W-WW){1'b0}}, ic2});
    den3 <= nwc_pkg::DEN_W'(ip2) * nwc_pkg::DEN_W'(ip2)
          + nwc_pkg::DEN_W'(ic2) * nwc_pkg::DEN_W'(ic2);
    acc3 <= acc2;
    nw3  <= (ip2 == '0) && (ic2 == '0);

    sum4 <= {pp3[nwc_pkg::PROD_W-1], pp3} + {pc3[nwc_pkg::PROD_W-1], pc3};
    den4 <= den3;
    acc4 <= acc3;
    nw4  <= nw3;

    mag5            <= nwc_pkg::MAG_W'(sum_abs) * nwc_pkg::MAG_W'(nwc_pkg::WEIGHT_FULL);
    den5            <= den4;
    side5.acc       <= acc4;
    side5.neg       <= sum4[nwc_pkg::SUM_W-1];
    side5.no_weight <= nw4;
  end

  nwc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_mag    (mag5),
    .in_den    (den5),
    .in_side   (side5),
    .out_valid (dv),
    .out_quot  (dquot),
    .out_side  (dside)
  );

  // Truncation toward zero: divide magnitudes, then restore the sign.
  always_ff @(posedge clk) begin
    qs   <= dside.neg ? -$signed({1'b0, dquot}) : $signed({1'b0, dquot});
    accq <= dside.acc;
    nwq  <= dside.no_weight;
  end

  assign sat_hi = $signed({{(nwc_pkg::TOT_W-SB){1'b0}}, nwc_pkg::SAMPLE_MAX});
  assign sat_lo = $signed({{(nwc_pkg::TOT_W-SB){1'b1}}, nwc_pkg::SAMPLE_MIN});

  always_comb begin
    total = $signed({{(nwc_pkg::TOT_W-SB){accq[SB-1]}}, accq})
          + $signed({qs[nwc_pkg::MAG_W], qs});
  end

  always_ff @(posedge clk) begin
    if (nwq) begin
      acc_out   <= accq;
      no_weight <= 1'b1;
      saturated <= 1'b0;
    end else if (total > sat_hi) begin
      acc_out   <= $signed(nwc_pkg::SAMPLE_MAX);
      no_weight <= 1'b0;
      saturated <= 1'b1;
    end else if (total < sat_lo) begin
      acc_out   <= $signed(nwc_pkg::SAMPLE_MIN);
      no_weight <= 1'b0;
      saturated <= 1'b1;
    end else begin
      acc_out   <= total[SB-1:0];
      no_weight <= 1'b0;
      saturated <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(nwc_pkg::LATENCY) done)
    else $error("result strobe missing after request");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(no_weight && saturated))
    else $error("no_weight and saturated both set");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    done && no_weight |-> acc_out == $past(acc_in, nwc_pkg::LATENCY))
    else $error("zero-weight result does not pass the accumulator through");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    done && saturated |->
      (acc_out == $signed(nwc_pkg::SAMPLE_MAX)) || (acc_out == $signed(nwc_pkg::SAMPLE_MIN)))
    else $error("clipped result is not a range limit");
`endif

endmodule

@@ hdl/nwc_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the WOLA combiner.
// Depends on nwc_pkg for widths and the sideband struct that rides along.

module nwc_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [nwc_pkg::MAG_W-1:0]    in_mag,
  input  logic [nwc_pkg::DEN_W-1:0]    in_den,
  input  nwc_pkg::div_side_t           in_side,
  output logic                         out_valid,
  output logic [nwc_pkg::MAG_W-1:0]    out_quot,
  output nwc_pkg::div_side_t           out_side
);

  typedef struct packed {
    logic [nwc_pkg::DEN_W-1:0] rem;
    logic [nwc_pkg::MAG_W-1:0] dq;
  } div_acc_t;

  // Shift the next dividend bit into the remainder, subtract if it fits.
  function automatic div_acc_t div_step(input logic [nwc_pkg::DEN_W-1:0] rem,
                                        input logic [nwc_pkg::MAG_W-1:0] dq,
                                        input logic [nwc_pkg::DEN_W-1:0] den);
    logic [nwc_pkg::DEN_W:0] trial;
    logic [nwc_pkg::DEN_W:0] diff;
    logic                    fits;
    div_acc_t                res;
    trial   = {rem, dq[nwc_pkg::MAG_W-1]};
    diff    = trial - {1'b0, den};
    fits    = (trial >= {1'b0, den});
    res.rem = fits ? diff[nwc_pkg::DEN_W-1:0] : trial[nwc_pkg::DEN_W-1:0];
    res.dq  = {dq[nwc_pkg::MAG_W-2:0], fits};
    return res;
  endfunction

  logic                      valid_q [0:nwc_pkg::MAG_W-1];
  logic [nwc_pkg::DEN_W-1:0] rem_q   [0:nwc_pkg::MAG_W-1];
  logic [nwc_pkg::MAG_W-1:0] dq_q    [0:nwc_pkg::MAG_W-1];
  logic [nwc_pkg::DEN_W-1:0] den_q   [0:nwc_pkg::MAG_W-1];
  nwc_pkg::div_side_t        side_q  [0:nwc_pkg::MAG_W-1];
  div_acc_t                  step_res [0:nwc_pkg::MAG_W-1];

  always_comb begin
    step_res[0] = div_step('0, in_mag, in_den);
    for (int i = 1; i < nwc_pkg::MAG_W; i++) begin
      step_res[i] = div_step(rem_q[i-1], dq_q[i-1], den_q[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nwc_pkg::MAG_W; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      valid_q[0] <= in_valid;
      for (int i = 1; i < nwc_pkg::MAG_W; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    den_q[0]  <= in_den;
    side_q[0] <= in_side;
    for (int i = 1; i < nwc_pkg::MAG_W; i++) begin
      den_q[i]  <= den_q[i-1];
      side_q[i] <= side_q[i-1];
    end
    for (int i = 0; i < nwc_pkg::MAG_W; i++) begin
      rem_q[i] <= step_res[i].rem;
      dq_q[i]  <= step_res[i].dq;
    end
  end

  assign out_valid = valid_q[nwc_pkg::MAG_W-1];
  assign out_quot  = dq_q[nwc_pkg::MAG_W-1];
  assign out_side  = side_q[nwc_pkg::MAG_W-1];

endmodule
